// ===== hw/rtl/slfw_pkg.sv =====
// slfw_pkg: shared types, constants and segment tables for the segment lcd
// serial frame writer; no dependencies
`timescale 1ns / 1ps

package slfw_pkg;

	localparam int ADDR_BITS    = 6;
	localparam int MAX_RUN_BITS = 8;
	localparam int FRAME_W      = 3 + ADDR_BITS + 4 * MAX_RUN_BITS;
	localparam int NIB_W        = 3 + ADDR_BITS + 4;
	localparam int LEN_W        = 6;
	localparam int CNT_W        = 4;

	localparam logic [2:0] MODE_CMD = 3'b100;
	localparam logic [2:0] MODE_WR  = 3'b101;

	typedef enum logic [1:0] {
		REQ_CMD    = 2'd0,
		REQ_NIBBLE = 2'd1,
		REQ_RUN    = 2'd2,
		REQ_DIGIT  = 2'd3
	} req_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_SHIFT = 1'b1
	} state_t;

	typedef struct packed {
		req_t                   req_type;
		logic [ADDR_BITS-1:0]   address;
		logic [7:0]             payload;
		logic [CNT_W-1:0]       bit_count;
		logic [1:0]             position;
		logic [3:0]             digit;
	} request_t;

	typedef struct packed {
		logic               drop;
		logic [FRAME_W-1:0] frame;
		logic [LEN_W-1:0]   len;
		logic [NIB_W-1:0]   pend_frame;
		logic               pend_valid;
	} frame_plan_t;

	typedef struct packed {
		logic             busy;
		logic [LEN_W-1:0] left;
		logic             pend_valid;
	} shift_status_t;

	function automatic logic [3:0] rev4(input logic [3:0] d);
		return {d[0], d[1], d[2], d[3]};
	endfunction

	function automatic logic [NIB_W-1:0] nibble_frame(input logic [ADDR_BITS-1:0] a,
		input logic [3:0] d);
		return {MODE_WR, a, rev4(d)};
	endfunction

	function automatic logic [7:0] seg_hex(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'h0: s = 8'hAF;
			4'h1: s = 8'h06;
			4'h2: s = 8'hCB;
			4'h3: s = 8'h4F;
			4'h4: s = 8'h66;
			4'h5: s = 8'h6D;
			4'h6: s = 8'hED;
			4'h7: s = 8'h07;
			4'h8: s = 8'hEF;
			4'h9: s = 8'h6F;
			4'hA: s = 8'hE7;
			4'hB: s = 8'hEC;
			4'hC: s = 8'hA9;
			4'hD: s = 8'hCE;
			4'hE: s = 8'hE9;
			4'hF: s = 8'hE1;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] seg_dec(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'd0: s = 8'hEB;
			4'd1: s = 8'h60;
			4'd2: s = 8'hC7;
			4'd3: s = 8'hE5;
			4'd4: s = 8'h6C;
			4'd5: s = 8'hAD;
			4'd6: s = 8'hAF;
			4'd7: s = 8'hE0;
			4'd8: s = 8'hEF;
			4'd9: s = 8'hED;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// ===== hw/rtl/segment_lcd_serial_frame_writer.sv =====
// segment_lcd_serial_frame_writer: top level of the 3-wire segment lcd frame
// writer; depends on slfw_pkg, slfw_frame_build and slfw_shifter
`timescale 1ns / 1ps

// Usage:
// s_* takes one request: s_tuser is the request kind, s_tdata holds address,
// payload, bit count, position and digit. m_* gives the serial bits one per
// transfer: m_tdata[0] is the data level, m_tuser[0] marks the bit after which
// chip select is released, m_tlast marks the final bit of the request.
// A request is taken only while no frame is being shifted; it then sends 12
// bits for a command, 13 for a nibble write, 9 + 4 * count (up to 41) for a
// bit run and 26 for a digit through the single frame shift register, one bit
// per cycle while the output register can take it. The first bit goes through
// the shift register, then the output register; a new request can be taken in
// the cycle after the last bit enters the output register. Digit requests with
// a bad position or digit produce no bits and leave the block idle.
// With m_tready low a full output register holds and the shifter waits.
// Reset clears the sequencer and the output valid; no request is pending.

module segment_lcd_serial_frame_writer import slfw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // address, payload, bit_count, position, digit
	input  logic [1:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // data_bit, zero fill
	output logic [0:0]  m_tuser,   // frame_end
	output logic        m_tlast
);

	request_t      req;
	frame_plan_t   plan;
	shift_status_t status;
	logic          idle;
	logic          data_bit;

	assign req.req_type  = req_t'(s_tuser);
	assign req.address   = s_tdata[5:0];
	assign req.payload   = s_tdata[13:6];
	assign req.bit_count = s_tdata[17:14];
	assign req.position  = s_tdata[19:18];
	assign req.digit     = s_tdata[23:20];

	slfw_frame_build u_build (
		.req  (req),
		.plan (plan)
	);

	slfw_shifter u_shift (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (s_tvalid && s_tready),
		.plan          (plan),
		.idle          (idle),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.out_bit       (data_bit),
		.out_frame_end (m_tuser[0]),
		.out_last      (m_tlast),
		.status        (status)
	);

	assign s_tready = idle;
	assign m_tdata  = {7'd0, data_bit};

	a_busy_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		status.busy |-> (status.left != '0))
		else $error("shifter busy with no bits left");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser[0])
		else $error("last bit of request does not end a frame");

	a_pend_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.pend_valid |-> status.busy)
		else $error("second frame pending while idle");

	a_req_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser != REQ_DIGIT)) |=> status.busy)
		else $error("accepted request did not start a frame");

endmodule

// ===== hw/rtl/slfw_frame_build.sv =====
// slfw_frame_build: turns one request into an msb-aligned frame, its length
// and an optional second nibble frame; depends on slfw_pkg
`timescale 1ns / 1ps

module slfw_frame_build import slfw_pkg::*; (
	input  request_t    req,
	output frame_plan_t plan
);

	localparam int RUN_TOP = FRAME_W - 1 - 3 - ADDR_BITS;

	logic [CNT_W-1:0] cnt_sat;
	logic [7:0]       seg;
	logic [ADDR_BITS-1:0] base;
	logic [3:0]       hi_nib;

	always_comb begin
		plan = '0;
		cnt_sat = (req.bit_count > CNT_W'(MAX_RUN_BITS)) ? CNT_W'(MAX_RUN_BITS) : req.bit_count;
		seg = (req.position == 2'd3) ? seg_dec(req.digit) : seg_hex(req.digit);
		base = (req.position == 2'd3) ? ADDR_BITS'(1)
			: ((req.position == 2'd1) ? ADDR_BITS'(4) : ADDR_BITS'(6));
		hi_nib = (req.position == 2'd3) ? (seg[7:4] | 4'd1) : seg[7:4];
		unique case (req.req_type)
			REQ_CMD: begin
				plan.frame[FRAME_W-1 -: 12] = {MODE_CMD, req.payload, 1'b0};
				plan.len = LEN_W'(12);
			end
			REQ_NIBBLE: begin
				plan.frame[FRAME_W-1 -: NIB_W] = nibble_frame(req.address, req.payload[3:0]);
				plan.len = LEN_W'(NIB_W);
			end
			REQ_RUN: begin
				plan.frame[FRAME_W-1 -: 3 + ADDR_BITS] = {MODE_WR, req.address};
				// bits past the length are never shifted out
				for (int i = 0; i < MAX_RUN_BITS; i++) begin
					plan.frame[RUN_TOP - 4 * i] = req.payload[i];
				end
				plan.len = LEN_W'(3 + ADDR_BITS) + {cnt_sat[LEN_W-3:0], 2'b00};
			end
			REQ_DIGIT: begin
				plan.drop = (req.position == 2'd0)
					|| ((req.position == 2'd3) && (req.digit > 4'd9));
				plan.frame[FRAME_W-1 -: NIB_W] = nibble_frame(base, hi_nib);
				plan.pend_frame = nibble_frame(base + ADDR_BITS'(1), seg[3:0]);
				plan.pend_valid = 1'b1;
				plan.len = LEN_W'(NIB_W);
			end
			default: plan = '0;
		endcase
	end

endmodule

// ===== hw/rtl/slfw_shifter.sv =====
// slfw_shifter: frame shift register, bit counter and output register under a
// small sequencer; depends on slfw_pkg
`timescale 1ns / 1ps

module slfw_shifter import slfw_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  frame_plan_t   plan,
	output logic          idle,
	input  logic          out_ready,
	output logic          out_valid,
	output logic          out_bit,
	output logic          out_frame_end,
	output logic          out_last,
	output shift_status_t status
);

	state_t state_q, state_d;
	logic [FRAME_W-1:0] shift_q;
	logic [LEN_W-1:0]   left_q;
	logic [NIB_W-1:0]   pend_q;
	logic               pend_v_q;
	logic               ovalid_q, obit_q, oend_q, olast_q;
	logic               step;
	logic               frame_done;

	assign idle       = (state_q == ST_IDLE);
	assign step       = (state_q == ST_SHIFT) && (!ovalid_q || out_ready);
	assign frame_done = (left_q == LEN_W'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (load && !plan.drop) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (step && frame_done && !pend_v_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			left_q   <= '0;
			pend_v_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load && idle && !plan.drop) begin
				left_q   <= plan.len;
				pend_v_q <= plan.pend_valid;
			end else if (step) begin
				if (frame_done && pend_v_q) begin
					left_q   <= LEN_W'(NIB_W);
					pend_v_q <= 1'b0;
				end else begin
					left_q <= left_q - LEN_W'(1);
				end
			end
			if (step) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && idle) begin
			shift_q <= plan.frame;
			pend_q  <= plan.pend_frame;
		end else if (step) begin
			if (frame_done && pend_v_q) begin
				shift_q <= {pend_q, (FRAME_W - NIB_W)'(0)};
			end else begin
				shift_q <= {shift_q[FRAME_W-2:0], 1'b0};
			end
		end
		if (step) begin
			obit_q  <= shift_q[FRAME_W-1];
			oend_q  <= frame_done;
			olast_q <= frame_done && !pend_v_q;
		end
	end

	assign out_valid         = ovalid_q;
	assign out_bit           = obit_q;
	assign out_frame_end     = oend_q;
	assign out_last          = olast_q;
	assign status.busy       = (state_q == ST_SHIFT);
	assign status.left       = left_q;
	assign status.pend_valid = pend_v_q;

endmodule
